@@ src/bmhq_pkg.sv @@
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int ID_BITS       = 8;
  localparam int PRIORITY_BITS = 48;
  localparam int COUNT_BITS    = 7;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                     kind;
    logic [ID_BITS-1:0]       entry_id;
    logic [PRIORITY_BITS-1:0] entry_priority;
  } cmd_word_t;

  typedef struct packed {
    logic                     head_valid;
    logic [ID_BITS-1:0]       head_id;
    logic [PRIORITY_BITS-1:0] head_priority;
    logic [COUNT_BITS-1:0]    entry_count;
    logic [1:0]               status;
  } rsp_word_t;

  typedef struct packed {
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  function automatic logic serves_before(input entry_t x, input entry_t y);
    logic r;
    if (x.prio != y.prio) begin
      r = x.prio < y.prio;
    end else begin
      r = x.id < y.id;
    end
    return r;
  endfunction

endpackage

@@ src/binary_min_heap_queue.sv @@
`timescale 1ns / 1ps

// channel  dir  handshake             word
// cmd      in   cmd_valid, cmd_stall  bmhq_pkg::cmd_word_t
// rsp      out  rsp_valid, rsp_stall  bmhq_pkg::rsp_word_t
//
// one word in flight; cmd_stall is high from accept until its result is registered
// push: climbs k levels (at most log2 of capacity), one per heap read
// pop: descends level by level from the root; both children come from the two read ports
// full push, empty pop, a pop to empty and a push into an empty heap skip the sift states
// synchronous reset clears the count; the heap memory needs no clearing
// a stalled result holds in the output register while the next word is taken

module binary_min_heap_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  bmhq_pkg::cmd_word_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output bmhq_pkg::rsp_word_t rsp
);
  import bmhq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          busy;
  logic          res_valid, res_ready;
  rsp_word_t     res;
  logic          we;
  logic [AW-1:0] waddr, raddr0, raddr1;
  entry_t        wdata, rdata0, rdata1;

  bmhq_ctrl #(
    .CAPACITY(CAPACITY),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd(cmd),
    .busy(busy),
    .res_valid(res_valid),
    .res(res),
    .res_ready(res_ready),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr0(raddr0),
    .raddr1(raddr1),
    .rdata0(rdata0),
    .rdata1(rdata1)
  );

  bmhq_store #(
    .DEPTH(CAPACITY),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr0(raddr0),
    .raddr1(raddr1),
    .rdata0(rdata0),
    .rdata1(rdata1)
  );

  assign cmd_stall = busy;
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

@@ src/bmhq_store.sv @@
`timescale 1ns / 1ps

module bmhq_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  bmhq_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output bmhq_pkg::entry_t rdata0,
  output bmhq_pkg::entry_t rdata1
);
  import bmhq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

@@ src/bmhq_ctrl.sv @@
`timescale 1ns / 1ps

module bmhq_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  bmhq_pkg::cmd_word_t cmd,
  output logic                busy,
  output logic                res_valid,
  output bmhq_pkg::rsp_word_t res,
  input  logic                res_ready,
  output logic                we,
  output logic [AW-1:0]       waddr,
  output bmhq_pkg::entry_t    wdata,
  output logic [AW-1:0]       raddr0,
  output logic [AW-1:0]       raddr1,
  input  bmhq_pkg::entry_t    rdata0,
  input  bmhq_pkg::entry_t    rdata1
);
  import bmhq_pkg::*;

  localparam int PW = AW + 2;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_UP_CMP  = 6'b000010,
    S_PLACE   = 6'b000100,
    S_DN_LAST = 6'b001000,
    S_DN_CMP  = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [AW-1:0]  pos, pos_next;
  entry_t         mov, mov_next;
  logic [1:0]     status, status_next;
  entry_t         head;

  logic [PW-1:0]  l_w, r_w;
  logic           l_ok, r_ok, l_win, r_win;
  entry_t         best_e;
  logic [AW-1:0]  best_a;
  entry_t         cmd_e;

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
    logic [AW-1:0] pm1;
    pm1 = p - 1'b1;
    return pm1 >> 1;
  endfunction

  function automatic logic [PW-1:0] left_of(input logic [AW-1:0] p);
    return PW'({p, 1'b1});
  endfunction

  assign cmd_e.id   = cmd.entry_id;
  assign cmd_e.prio = cmd.entry_priority;

  // child selection for sift down
  always_comb begin
    l_w    = left_of(pos);
    r_w    = l_w + 1'b1;
    l_ok   = l_w < PW'(cnt);
    r_ok   = r_w < PW'(cnt);
    best_e = mov;
    best_a = pos;
    l_win  = 1'b0;
    r_win  = 1'b0;
    if (l_ok && serves_before(rdata0, mov)) begin
      l_win  = 1'b1;
      best_e = rdata0;
      best_a = l_w[AW-1:0];
    end
    if (r_ok && serves_before(rdata1, best_e)) begin
      r_win  = 1'b1;
      best_e = rdata1;
      best_a = r_w[AW-1:0];
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    pos_next    = pos;
    mov_next    = mov;
    status_next = status;
    we          = 1'b0;
    waddr       = pos;
    wdata       = mov;
    raddr0      = '0;
    raddr1      = '0;
    res_valid   = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          status_next = ST_OK;
          if (cmd.kind == KIND_PUSH) begin
            if (cnt == CAP_C) begin
              status_next = ST_FULL;
              state_next  = S_FIN;
            end else begin
              mov_next = cmd_e;
              pos_next = cnt[AW-1:0];
              cnt_next = cnt + 1'b1;
              if (cnt == '0) begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = cmd_e;
                state_next = S_FIN;
              end else begin
                raddr0     = parent_of(cnt[AW-1:0]);
                state_next = S_UP_CMP;
              end
            end
          end else begin
            if (cnt == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_FIN;
            end else begin
              cnt_next = cnt - 1'b1;
              if (cnt == CW'(1)) begin
                state_next = S_FIN;
              end else begin
                raddr0     = cnt_next[AW-1:0];
                state_next = S_DN_LAST;
              end
            end
          end
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (serves_before(mov, rdata0)) begin
          wdata    = rdata0;
          pos_next = parent_of(pos);
          if (parent_of(pos) == '0) begin
            state_next = S_PLACE;
          end else begin
            raddr0 = parent_of(parent_of(pos));
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_PLACE: begin
        we         = 1'b1;
        state_next = S_FIN;
      end
      S_DN_LAST: begin
        mov_next   = rdata0;
        pos_next   = '0;
        raddr0     = AW'(left_of('0));
        raddr1     = AW'(left_of('0) + 1'b1);
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        we    = 1'b1;
        wdata = best_e;
        if (l_win || r_win) begin
          pos_next = best_a;
          raddr0   = AW'(left_of(best_a));
          raddr1   = AW'(left_of(best_a) + 1'b1);
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    mov    <= mov_next;
    status <= status_next;
    if (we && waddr == '0) begin
      head <= wdata;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    res.head_valid    = cnt != '0;
    res.head_id       = (cnt != '0) ? head.id : '0;
    res.head_priority = (cnt != '0) ? head.prio : '0;
    res.entry_count   = COUNT_BITS'(cnt);
    res.status        = status;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_C)
    else $error("entry count above capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_valid) |=> (state != S_IDLE))
    else $error("accepted word did not start work");

  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    we |-> (CW'(waddr) < cnt_next))
    else $error("write outside live heap");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_FULL) |-> (cnt == CAP_C))
    else $error("full status while heap not full");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH = 64;
  localparam int RANDOM_ITEMS = 1950;
  localparam logic [PRIORITY_BITS-1:0] MAXP = {PRIORITY_BITS{1'b1}};

  typedef enum int {FILL, DRAIN, CHURN} phase_style_e;
  typedef enum int {KEY_WIDE, KEY_NARROW, KEY_EDGE} key_style_e;

  typedef struct {
    cmd_word_t w;
    bit        typed;
    rsp_word_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_word_t cmd = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  entry_t      heap_slot [HEAP_DEPTH];
  int unsigned heap_fill = 0;
  rsp_word_t   head_reports [$];
  int          mismatch_count = 0;
  bit          no_idle = 1'b0;

  binary_min_heap_queue #(.CAPACITY(HEAP_DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  function automatic bit ranks_ahead(entry_t a, entry_t b);
    return (a.prio < b.prio) || (a.prio == b.prio && a.id < b.id);
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    entry_t t;
    t = heap_slot[a];
    heap_slot[a] = heap_slot[b];
    heap_slot[b] = t;
  endfunction

  // updates the heap copy and returns the head report for this word
  function automatic rsp_word_t apply_to_heap(cmd_word_t w);
    rsp_word_t   r;
    int unsigned pos;
    int unsigned best;
    int unsigned kid;
    bit          done;
    r = '0;
    r.status = ST_OK;
    if (w.kind == KIND_PUSH) begin
      if (heap_fill >= HEAP_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = heap_fill;
        heap_slot[pos].id = w.entry_id;
        heap_slot[pos].prio = w.entry_priority;
        heap_fill++;
        while (pos > 0 && ranks_ahead(heap_slot[pos], heap_slot[(pos - 1) / 2])) begin
          swap_slots(pos, (pos - 1) / 2);
          pos = (pos - 1) / 2;
        end
      end
    end else if (heap_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      heap_fill--;
      heap_slot[0] = heap_slot[heap_fill];
      pos = 0;
      done = 1'b0;
      while (!done) begin
        best = pos;
        kid = 2 * pos + 1;
        if (kid < heap_fill && ranks_ahead(heap_slot[kid], heap_slot[best])) best = kid;
        if (kid + 1 < heap_fill && ranks_ahead(heap_slot[kid + 1], heap_slot[best]))
          best = kid + 1;
        if (best == pos) begin
          done = 1'b1;
        end else begin
          swap_slots(pos, best);
          pos = best;
        end
      end
    end
    if (heap_fill > 0) begin
      r.head_valid = 1'b1;
      r.head_id = heap_slot[0].id;
      r.head_priority = heap_slot[0].prio;
    end
    r.entry_count = COUNT_BITS'(heap_fill);
    return r;
  endfunction

  function automatic rsp_word_t report(logic v, logic [ID_BITS-1:0] id,
                                       logic [PRIORITY_BITS-1:0] pr,
                                       logic [COUNT_BITS-1:0] cnt, logic [1:0] st);
    rsp_word_t r;
    r.head_valid = v;
    r.head_id = id;
    r.head_priority = pr;
    r.entry_count = cnt;
    r.status = st;
    return r;
  endfunction

  function automatic stim_row_t row(logic k, logic [ID_BITS-1:0] id,
                                    logic [PRIORITY_BITS-1:0] pr, bit typed,
                                    rsp_word_t want);
    stim_row_t s;
    s.w.kind = k;
    s.w.entry_id = id;
    s.w.entry_priority = pr;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic logic [PRIORITY_BITS-1:0] pick_priority(key_style_e keys);
    logic [63:0] raw;
    logic [PRIORITY_BITS-1:0] p;
    raw = {$urandom, $urandom};
    case (keys)
      KEY_WIDE: p = raw[PRIORITY_BITS-1:0];
      KEY_NARROW: p = PRIORITY_BITS'($urandom_range(0, 7));
      default: begin
        case ($urandom_range(0, 3))
          0: p = '0;
          1: p = 1;
          2: p = MAXP - 1;
          default: p = MAXP;
        endcase
      end
    endcase
    return p;
  endfunction

  function automatic logic [ID_BITS-1:0] pick_id(key_style_e keys);
    logic [ID_BITS-1:0] id;
    case (keys)
      KEY_WIDE: id = ID_BITS'($urandom);
      KEY_NARROW: id = ID_BITS'($urandom_range(0, 3));
      default: id = $urandom_range(0, 1) ? '0 : {ID_BITS{1'b1}};
    endcase
    return id;
  endfunction

  task automatic send_word(cmd_word_t w, bit typed, rsp_word_t typed_want);
    rsp_word_t want;
    while (!no_idle && $urandom_range(0, 99) < 19) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    want = apply_to_heap(w);
    head_reports.push_back(typed ? typed_want : want);
  endtask

  task automatic wait_all_reported();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (head_reports.size() != 0) @(posedge clk);
  endtask

  function automatic void check_head_report(rsp_word_t got);
    rsp_word_t want;
    if (head_reports.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected word: id %0h prio %0h count %0d status %0d",
                 got.head_id, got.head_priority, got.entry_count, got.status);
      return;
    end
    want = head_reports.pop_front();
    if (got.head_valid !== want.head_valid || got.head_id !== want.head_id ||
        got.head_priority !== want.head_priority ||
        got.entry_count !== want.entry_count || got.status !== want.status) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch: exp v%0b id %0h prio %0h cnt %0d st %0d, got v%0b id %0h prio %0h cnt %0d st %0d",
                 want.head_valid, want.head_id, want.head_priority, want.entry_count,
                 want.status, got.head_valid, got.head_id, got.head_priority,
                 got.entry_count, got.status);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) check_head_report(rsp);
    rsp_stall <= !no_idle && ($urandom_range(0, 99) < 19);
  end

  initial begin
    stim_row_t    directed [$];
    stim_row_t    s;
    phase_style_e style;
    key_style_e   keys;
    int           random_sent;
    int           phase_idx;
    int           span;
    int           push_pct;
    cmd_word_t    w;

    // pops carry junk keys, which must be ignored
    directed.push_back(row(KIND_POP, 8'h3C, 48'hDEAD_BEEF_CAFE, 1,
                           report(0, 0, 0, 0, ST_EMPTY)));
    directed.push_back(row(KIND_PUSH, 8'hFF, MAXP, 1, report(1, 8'hFF, MAXP, 1, ST_OK)));
    directed.push_back(row(KIND_PUSH, 8'h00, MAXP, 1, report(1, 8'h00, MAXP, 2, ST_OK)));
    directed.push_back(row(KIND_PUSH, 8'h80, '0, 1, report(1, 8'h80, '0, 3, ST_OK)));
    directed.push_back(row(KIND_PUSH, 8'h00, '0, 1, report(1, 8'h00, '0, 4, ST_OK)));
    directed.push_back(row(KIND_PUSH, 8'h01, '0, 1, report(1, 8'h00, '0, 5, ST_OK)));
    directed.push_back(row(KIND_PUSH, 8'hAA, 48'hAAAA_AAAA_AAAA, 0, '0));
    directed.push_back(row(KIND_PUSH, 8'h55, 48'h5555_5555_5555, 0, '0));
    directed.push_back(row(KIND_PUSH, 8'h7F, 48'h8000_0000_0000, 0, '0));
    directed.push_back(row(KIND_PUSH, 8'hFE, 48'h0000_0000_0001, 0, '0));
    repeat (8) directed.push_back(row(KIND_POP, 8'hFF, MAXP, 0, '0));
    directed.push_back(row(KIND_POP, 8'h3C, 48'hDEAD_BEEF_CAFE, 1,
                           report(0, 0, 0, 0, ST_OK)));
    directed.push_back(row(KIND_POP, 8'hFF, MAXP, 1, report(0, 0, 0, 0, ST_EMPTY)));
    directed.push_back(row(KIND_PUSH, 8'h01, 48'h0000_FFFF_0000, 1,
                           report(1, 8'h01, 48'h0000_FFFF_0000, 1, ST_OK)));
    directed.push_back(row(KIND_POP, 8'h00, '0, 1, report(0, 0, 0, 0, ST_OK)));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      s = directed[i];
      send_word(s.w, s.typed, s.want);
    end

    random_sent = 0;
    phase_idx = 0;
    while (random_sent < RANDOM_ITEMS) begin
      style = phase_style_e'($urandom_range(0, 2));
      keys = key_style_e'($urandom_range(0, 2));
      span = $urandom_range(16, 130);
      case (style)
        FILL: push_pct = 92;
        DRAIN: push_pct = 10;
        default: push_pct = 50;
      endcase
      if (phase_idx == 2 || $urandom_range(0, 4) == 0) wait_all_reported();
      no_idle = (random_sent >= 700 && random_sent < 1000);
      for (int i = 0; i < span && random_sent < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          w.kind = KIND_PUSH;
          w.entry_id = pick_id(keys);
          w.entry_priority = pick_priority(keys);
        end else begin
          w.kind = KIND_POP;
          w.entry_id = ID_BITS'($urandom);
          w.entry_priority = pick_priority(KEY_WIDE);
        end
        send_word(w, 1'b0, '0);
        random_sent++;
      end
      phase_idx++;
    end
    no_idle = 1'b0;

    wait_all_reported();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("binary_min_heap_queue regression: pass");
    end else begin
      $display("binary_min_heap_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("binary_min_heap_queue regression: fail");
    $finish;
  end

endmodule
